FILE: rtl/array_linked_list_manager_macros.svh
// assertion macros for the linked list manager
`ifndef ARRAY_LINKED_LIST_MANAGER_MACROS_SVH
`define ARRAY_LINKED_LIST_MANAGER_MACROS_SVH

// same-cycle implication
`define ALM_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication a fixed number of cycles later
`define ALM_ASSERT_AFTER(name, clk, rst, ante, cycles, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> ## cycles (cons)) \
      else $error(msg);

`endif

FILE: rtl/alm_pkg.sv
// shared types and constants of the linked list manager
package alm_pkg;

   localparam int DEF_CAPACITY    = 256;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int IDX_PORT_W  = 8;
   localparam int DATA_PORT_W = 32;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_AFTER  = 2'd0,
      CMD_INS_BEFORE = 2'd1,
      CMD_ERASE      = 2'd2,
      CMD_READ       = 2'd3
   } alm_cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_NOELEM = 2'd1,
      STAT_FULL   = 2'd2
   } alm_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_MODIFY,
      ST_FINISH
   } alm_state_type;

endpackage

FILE: rtl/alm_ram.sv
// generic single-write single-read ram with registered read data
module alm_ram #(
   parameter int WIDTH = alm_pkg::DEF_VALUE_WIDTH,
   parameter int DEPTH = alm_pkg::DEF_CAPACITY
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/array_linked_list_manager.sv
// top level of the array based doubly linked list manager
// A doubly linked list lives in a node store of CAPACITY entries; entry 0 is the sentinel
// whose next link is the head and whose prev link is the tail, and free nodes are chained
// through their next links. Each request transaction is one command (insert after, insert
// before, erase, read) and yields exactly one response transaction that also reports head,
// tail, element count and the in-order flag. Node state sits in two rams with registered read
// data: a link ram holding {in use, next, value} and a prev ram. Every command reads the position's
// entry when accepted; in the look state it reads the anchor entry and writes the new or erased
// node; in the modify state it writes the neighbor links and prefetches the next free node.
// A new request is taken only in idle or once the previous one reaches finish; the next request
// can be accepted in the same cycle the previous response is loaded. After reset an
// initialization sweep writes the free chain into the rams, during which no request is taken;
// poison value writes on the csr port are accepted at any time.
module array_linked_list_manager #(
   parameter int CAPACITY    = alm_pkg::DEF_CAPACITY,
   parameter int VALUE_WIDTH = alm_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [alm_pkg::CMD_W-1:0]             req_command,
   input  logic [alm_pkg::IDX_PORT_W-1:0]        req_position,
   input  logic signed [alm_pkg::DATA_PORT_W-1:0] req_item_value,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [alm_pkg::STATUS_W-1:0]          rsp_status,
   output logic [alm_pkg::IDX_PORT_W-1:0]        rsp_new_index,
   output logic signed [alm_pkg::DATA_PORT_W-1:0] rsp_read_value,
   output logic [alm_pkg::IDX_PORT_W-1:0]        rsp_head_index,
   output logic [alm_pkg::IDX_PORT_W-1:0]        rsp_tail_index,
   output logic [alm_pkg::IDX_PORT_W-1:0]        rsp_element_count,
   output logic                                  rsp_in_order,
   // poison value register
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic signed [alm_pkg::DATA_PORT_W-1:0] csr_poison_value
);

`include "array_linked_list_manager_macros.svh"

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int EXT_W = (IDX_W > alm_pkg::IDX_PORT_W) ? IDX_W : alm_pkg::IDX_PORT_W;
   localparam int A_W   = 1 + IDX_W + VALUE_WIDTH;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   // sequencing
   alm_pkg::alm_state_type state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic             accept;
   logic             rsp_slot_free;
   logic             rsp_load;

   // captured request transaction
   alm_pkg::alm_cmd_type   cmd_ff;
   logic [IDX_W-1:0]       pos_ff;
   logic                   pos_ok_ff;
   logic [VALUE_WIDTH-1:0] val_ff;

   logic [EXT_W-1:0]       req_pos_ext;
   logic [IDX_W-1:0]       req_addr;
   logic                   req_in_range;
   logic [63:0]            req_val_ext;

   // list state kept in flops
   logic [IDX_W-1:0] count_ff, count_in;
   logic             order_ff, order_in;
   logic [IDX_W-1:0] free_head_ff, free_head_in;
   logic [IDX_W-1:0] free_next_ff, free_next_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             fetch_ff, fetch_in;
   logic [alm_pkg::DATA_PORT_W-1:0] poison_ff;

   // second write pass, set up in the look cycle
   logic             mod_we_ff, mod_we_in;
   logic [IDX_W-1:0] mod_a_addr_ff, mod_a_addr_in;
   logic [IDX_W-1:0] mod_a_next_ff, mod_a_next_in;
   logic [IDX_W-1:0] mod_b_addr_ff, mod_b_addr_in;
   logic [IDX_W-1:0] mod_b_data_ff, mod_b_data_in;

   // result held until the finish cycle
   alm_pkg::alm_status_type          res_status_ff, res_status_in;
   logic [alm_pkg::IDX_PORT_W-1:0]   res_new_ff, res_new_in;
   logic [alm_pkg::DATA_PORT_W-1:0]  res_read_ff, res_read_in;

   // response register
   logic                             rsp_valid_ff;
   logic [alm_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [alm_pkg::IDX_PORT_W-1:0]   rsp_new_ff;
   logic [alm_pkg::DATA_PORT_W-1:0]  rsp_read_ff;
   logic [alm_pkg::IDX_PORT_W-1:0]   rsp_head_ff;
   logic [alm_pkg::IDX_PORT_W-1:0]   rsp_tail_ff;
   logic [alm_pkg::IDX_PORT_W-1:0]   rsp_count_ff;
   logic                             rsp_order_ff;

   // ram ports
   logic             a_we;
   logic [IDX_W-1:0] a_waddr, a_raddr;
   logic [A_W-1:0]   a_wdata, a_rdata;
   logic             b_we;
   logic [IDX_W-1:0] b_waddr, b_raddr;
   logic [IDX_W-1:0] b_wdata, b_rdata;

   // fields of the link ram word {in use, next, value}
   logic                   a_use;
   logic [IDX_W-1:0]       a_next;
   logic [VALUE_WIDTH-1:0] a_val;
   logic [63:0]            a_val_ext;

   // look cycle decode
   logic             is_ins;
   logic             node_ok;
   logic             do_ins;
   logic             do_era;
   logic [IDX_W-1:0] anchor;
   logic [IDX_W-1:0] ins_next;
   logic [IDX_W-1:0] clr_next;
   logic [EXT_W-1:0] new_ext;
   logic [EXT_W-1:0] head_ext;
   logic [EXT_W-1:0] tail_ext;
   logic [EXT_W-1:0] count_ext;

   // ---------------------------------------------------------------- rams
   alm_ram #(
      .WIDTH (A_W),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (a_waddr),
      .wr_data (a_wdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   alm_ram #(
      .WIDTH (IDX_W),
      .DEPTH (CAPACITY)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   assign a_use     = a_rdata[A_W-1];
   assign a_next    = a_rdata[VALUE_WIDTH +: IDX_W];
   assign a_val     = a_rdata[VALUE_WIDTH-1:0];
   assign a_val_ext = 64'(a_val);

   // ---------------------------------------------------------------- request side
   assign req_pos_ext  = EXT_W'(req_position);
   assign req_addr     = req_pos_ext[IDX_W-1:0];
   assign req_in_range = (32'(req_position) < 32'(CAPACITY));
   // stored values keep only their low VALUE_WIDTH bits
   assign req_val_ext  = 64'(unsigned'(req_item_value));

   assign rsp_slot_free = !rsp_valid_ff || !rsp_stall;
   assign accept        = req_valid && !req_stall;

   assign csr_ready = 1'b1;

   // sweep pattern: entry i points at i plus one, sentinel and last entry point at 0
   assign clr_next = (clr_ff == '0 || clr_ff == LAST_IDX) ? '0 : clr_ff + 1'b1;

   // ---------------------------------------------------------------- look cycle decode
   // a_rdata / b_rdata hold the position's entries in the look cycle
   always_comb begin
      is_ins   = (cmd_ff == alm_pkg::CMD_INS_AFTER) || (cmd_ff == alm_pkg::CMD_INS_BEFORE);
      node_ok  = pos_ok_ff && a_use;
      // insert before links in after the predecessor; before the sentinel is an append
      anchor   = (cmd_ff == alm_pkg::CMD_INS_AFTER) ? pos_ff : b_rdata;
      ins_next = (cmd_ff == alm_pkg::CMD_INS_AFTER) ? a_next : pos_ff;
      do_ins   = node_ok && is_ins && (free_head_ff != '0);
      // the sentinel is never erased
      do_era   = node_ok && (cmd_ff == alm_pkg::CMD_ERASE) && (pos_ff != '0);
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         alm_pkg::ST_CLEAR:  state_in = (clr_ff == LAST_IDX) ? alm_pkg::ST_IDLE
                                                             : alm_pkg::ST_CLEAR;
         alm_pkg::ST_IDLE:   state_in = accept ? alm_pkg::ST_LOOK : alm_pkg::ST_IDLE;
         alm_pkg::ST_LOOK:   state_in = alm_pkg::ST_MODIFY;
         alm_pkg::ST_MODIFY: state_in = alm_pkg::ST_FINISH;
         alm_pkg::ST_FINISH: begin
            if (accept) begin
               state_in = alm_pkg::ST_LOOK;
            end else if (rsp_slot_free) begin
               state_in = alm_pkg::ST_IDLE;
            end else begin
               state_in = alm_pkg::ST_FINISH;
            end
         end
         default:            state_in = alm_pkg::ST_CLEAR;
      endcase
   end

   // ---------------------------------------------------------------- state outputs
   always_comb begin
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      clr_in    = clr_ff;
      a_we      = 1'b0;
      a_waddr   = mod_a_addr_ff;
      a_wdata   = {1'b1, mod_a_next_ff, a_val};
      a_raddr   = req_addr;
      b_we      = 1'b0;
      b_waddr   = mod_b_addr_ff;
      b_wdata   = mod_b_data_ff;
      b_raddr   = req_addr;
      unique case (state_ff)
         alm_pkg::ST_CLEAR: begin
            clr_in  = clr_ff + 1'b1;
            a_we    = 1'b1;
            a_waddr = clr_ff;
            a_wdata = {(clr_ff == '0), clr_next, {VALUE_WIDTH{1'b0}}};
            b_we    = 1'b1;
            b_waddr = clr_ff;
            b_wdata = '0;
         end
         alm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         alm_pkg::ST_LOOK: begin
            // fetch the anchor (insert) or predecessor (erase) entry
            a_raddr = anchor;
            if (do_ins) begin
               // new node takes the free head
               a_we    = 1'b1;
               a_waddr = free_head_ff;
               a_wdata = {1'b1, ins_next, val_ff};
               b_we    = 1'b1;
               b_waddr = free_head_ff;
               b_wdata = anchor;
            end else if (do_era) begin
               // erased node goes on top of the free chain
               a_we    = 1'b1;
               a_waddr = pos_ff;
               a_wdata = {1'b0, free_head_ff, {VALUE_WIDTH{1'b0}}};
               b_we    = 1'b1;
               b_waddr = pos_ff;
               b_wdata = '0;
            end
         end
         alm_pkg::ST_MODIFY: begin
            // prefetch the link of the new free head
            a_raddr = free_next_ff;
            a_we    = mod_we_ff;
            b_we    = mod_we_ff;
         end
         alm_pkg::ST_FINISH: begin
            rsp_load  = rsp_slot_free;
            req_stall = !rsp_slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ---------------------------------------------------------------- list bookkeeping
   always_comb begin
      count_in      = count_ff;
      order_in      = order_ff;
      free_head_in  = free_head_ff;
      free_next_in  = free_next_ff;
      fetch_in      = fetch_ff;
      mod_we_in     = mod_we_ff;
      mod_a_addr_in = mod_a_addr_ff;
      mod_a_next_in = mod_a_next_ff;
      mod_b_addr_in = mod_b_addr_ff;
      mod_b_data_in = mod_b_data_ff;
      res_status_in = res_status_ff;
      res_new_in    = res_new_ff;
      res_read_in   = res_read_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      new_ext       = EXT_W'(free_head_ff);

      if (state_ff == alm_pkg::ST_LOOK) begin
         mod_we_in   = do_ins || do_era;
         fetch_in    = do_ins;
         res_new_in  = do_ins ? new_ext[alm_pkg::IDX_PORT_W-1:0] : '0;
         res_read_in = '0;
         priority if (!node_ok) begin
            res_status_in = alm_pkg::STAT_NOELEM;
         end else if (is_ins && (free_head_ff == '0)) begin
            res_status_in = alm_pkg::STAT_FULL;
         end else if ((cmd_ff == alm_pkg::CMD_ERASE) && (pos_ff == '0)) begin
            res_status_in = alm_pkg::STAT_NOELEM;
         end else begin
            res_status_in = alm_pkg::STAT_OK;
            if (cmd_ff == alm_pkg::CMD_READ) begin
               res_read_in = (pos_ff == '0) ? poison_ff
                                            : a_val_ext[alm_pkg::DATA_PORT_W-1:0];
            end
         end

         if (do_ins) begin
            count_in      = count_ff + 1'b1;
            free_head_in  = free_next_ff;
            // any insert not hanging off the tail breaks order
            if (anchor != tail_ff) begin
               order_in = 1'b0;
            end
            mod_a_addr_in = anchor;
            mod_a_next_in = free_head_ff;
            mod_b_addr_in = ins_next;
            mod_b_data_in = free_head_ff;
         end else if (do_era) begin
            count_in      = count_ff - 1'b1;
            free_head_in  = pos_ff;
            free_next_in  = free_head_ff;
            if (pos_ff != tail_ff) begin
               order_in = 1'b0;
            end
            // bridge predecessor and successor
            mod_a_addr_in = b_rdata;
            mod_a_next_in = a_next;
            mod_b_addr_in = a_next;
            mod_b_data_in = b_rdata;
         end
      end

      if (state_ff == alm_pkg::ST_MODIFY) begin
         mod_we_in = 1'b0;
      end

      // prefetched link of the free head lands in the first finish cycle
      if (state_ff == alm_pkg::ST_FINISH) begin
         fetch_in = 1'b0;
         if (fetch_ff) begin
            free_next_in = a_next;
         end
      end

      // head and tail shadow the sentinel's links
      if (a_we && (a_waddr == '0)) begin
         head_in = a_wdata[VALUE_WIDTH +: IDX_W];
      end
      if (b_we && (b_waddr == '0)) begin
         tail_in = b_wdata;
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alm_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         order_ff     <= 1'b1;
         free_head_ff <= IDX_W'(1);
         free_next_ff <= IDX_W'(2);
         head_ff      <= '0;
         tail_ff      <= '0;
         fetch_ff     <= 1'b0;
         mod_we_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         poison_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         order_ff     <= order_in;
         free_head_ff <= free_head_in;
         free_next_ff <= free_next_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fetch_ff     <= fetch_in;
         mod_we_ff    <= mod_we_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
         if (csr_valid && csr_ready) begin
            poison_ff <= unsigned'(csr_poison_value);
         end
      end
   end

   // ---------------------------------------------------------------- payload registers
   assign head_ext  = EXT_W'(head_ff);
   assign tail_ext  = EXT_W'(tail_ff);
   assign count_ext = EXT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= alm_pkg::alm_cmd_type'(req_command);
         pos_ff    <= req_addr;
         pos_ok_ff <= req_in_range;
         val_ff    <= req_val_ext[VALUE_WIDTH-1:0];
      end
      mod_a_addr_ff <= mod_a_addr_in;
      mod_a_next_ff <= mod_a_next_in;
      mod_b_addr_ff <= mod_b_addr_in;
      mod_b_data_ff <= mod_b_data_in;
      res_status_ff <= res_status_in;
      res_new_ff    <= res_new_in;
      res_read_ff   <= res_read_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_new_ff    <= res_new_ff;
         rsp_read_ff   <= res_read_ff;
         rsp_head_ff   <= head_ext[alm_pkg::IDX_PORT_W-1:0];
         rsp_tail_ff   <= tail_ext[alm_pkg::IDX_PORT_W-1:0];
         rsp_count_ff  <= count_ext[alm_pkg::IDX_PORT_W-1:0];
         rsp_order_ff  <= order_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_new_index     = rsp_new_ff;
   assign rsp_read_value    = signed'(rsp_read_ff);
   assign rsp_head_index    = rsp_head_ff;
   assign rsp_tail_index    = rsp_tail_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_in_order      = rsp_order_ff;

   // ---------------------------------------------------------------- assertions
   // an empty free chain means every non-sentinel node is in the list
   `ALM_ASSERT_NOW(a_full_count, clock, reset, free_head_ff == '0, count_ff == LAST_IDX, "free chain empty with nodes unaccounted")
   // between commands head and count agree on emptiness
   `ALM_ASSERT_NOW(a_head_count, clock, reset, state_ff == alm_pkg::ST_IDLE || state_ff == alm_pkg::ST_FINISH, (head_ff == '0) == (count_ff == '0), "head and element count disagree")
   // every accepted transaction passes through look and modify into the finish cycle
   `ALM_ASSERT_AFTER(a_latency, clock, reset, accept, 3, state_ff == alm_pkg::ST_FINISH, "command did not finish in three cycles")

endmodule
